[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file aes_enc_checker.sv.
// No dependencies; AEC_ASSERT expects signals named clk and arst_n in scope, AEC_ASSERT_ANY only clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, ignored while reset is held
`define AEC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also runs around reset
`define AEC_ASSERT_ANY(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/aes_enc_pkg.sv]
// Shared types, constants and round functions of the AES encrypt core.
// No dependencies.
package aes_enc_pkg;

	localparam int MaxRounds = 14;
	localparam int KeyWords  = 4 * (MaxRounds + 1);
	localparam int RkIdxW    = $clog2(KeyWords);

	// Key length codes; code 3 is saturated to the 256-bit key
	typedef enum logic [1:0] {
		KLEN_128 = 2'd0,
		KLEN_192 = 2'd1,
		KLEN_256 = 2'd2
	} klen_t;

	// Configuration register indexes
	localparam logic [2:0] REG_KEY_LENGTH = 3'd0;
	localparam logic [2:0] REG_KEY_PART_0 = 3'd1;
	localparam logic [2:0] REG_KEY_PART_1 = 3'd2;
	localparam logic [2:0] REG_KEY_PART_2 = 3'd3;
	localparam logic [2:0] REG_KEY_PART_3 = 3'd4;

	localparam logic [3:0] ROUNDS_128 = 4'd10;
	localparam logic [3:0] ROUNDS_192 = 4'd12;
	localparam logic [3:0] ROUNDS_256 = 4'd14;

	localparam logic [RkIdxW-1:0] WORDS_128 = RkIdxW'(44);
	localparam logic [RkIdxW-1:0] WORDS_192 = RkIdxW'(52);
	localparam logic [RkIdxW-1:0] WORDS_256 = RkIdxW'(60);

	// Per-cell control: pass the state through, or run the final round
	typedef struct packed {
		logic bypass;
		logic last;
	} cell_ctl_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	// Multiply by x in GF(2^8)
	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	// SubBytes and ShiftRows; byte n sits at bits [127-8n -: 8]
	function automatic logic [127:0] sub_shift(input logic [127:0] s);
		logic [127:0] t;
		int src;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				src = r + 4 * ((c + r) % 4);
				t[127 - 8 * (r + 4 * c) -: 8] = SBOX[s[127 - 8 * src -: 8]];
			end
		end
		return t;
	endfunction

	function automatic logic [127:0] mix_columns(input logic [127:0] s);
		logic [127:0] t;
		logic [7:0] a0, a1, a2, a3, all;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			a0  = s[127 - 32 * c -: 8];
			a1  = s[119 - 32 * c -: 8];
			a2  = s[111 - 32 * c -: 8];
			a3  = s[103 - 32 * c -: 8];
			all = a0 ^ a1 ^ a2 ^ a3;
			t[127 - 32 * c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
			t[119 - 32 * c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
			t[111 - 32 * c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
			t[103 - 32 * c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
		end
		return t;
	endfunction

endpackage

[hw/rtl/aes_enc_cell.sv]
// One round cell of the AES encrypt chain: a full, final or pass-through round.
// Depends on aes_enc_pkg.
module aes_enc_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  aes_enc_pkg::cell_ctl_t ctl,
	input  logic [127:0]           rkey,
	input  logic                   valid_in,
	input  logic [127:0]           state_in,
	input  logic                   ready_dn,
	output logic                   ready_up,
	output logic                   valid_q,
	output logic [127:0]           state_q
);

	logic [127:0] ss;
	logic [127:0] mixed;
	logic [127:0] state_nxt;

	// Stage loads when empty or when the next stage takes its item
	assign ready_up = !valid_q || ready_dn;

	// Round function
	always_comb begin
		ss        = aes_enc_pkg::sub_shift(state_in);
		mixed     = ctl.last ? ss : aes_enc_pkg::mix_columns(ss);
		state_nxt = ctl.bypass ? state_in : (mixed ^ rkey);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready_up) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_up) begin
			state_q <= state_nxt;
		end
	end

endmodule

[hw/rtl/aes_enc_kexp.sv]
// AES key expansion: one round-key word per cycle into a round key register file.
// Depends on aes_enc_pkg.
module aes_enc_kexp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  aes_enc_pkg::klen_t                     mode,
	input  logic [255:0]                           key,
	output logic                                   busy,
	output logic [aes_enc_pkg::KeyWords*32-1:0]    rk
);

	localparam int KW = aes_enc_pkg::KeyWords;
	localparam int IW = aes_enc_pkg::RkIdxW;

	logic          load_q;
	logic          run_q;
	logic [IW-1:0] idx_q;
	logic [2:0]    phase_q;
	logic [7:0]    rcon_q;
	logic [31:0]   win_q [8];
	logic [31:0]   rk_q [KW];

	logic [31:0]   kw [8];
	logic [31:0]   win_init [8];
	logic [31:0]   oldest;
	logic [31:0]   tmp;
	logic [31:0]   new_word;
	logic [2:0]    last_phase;
	logic [IW-1:0] total;
	logic [IW-1:0] first_idx;

	assign busy = load_q || run_q;

	// Key words and the per-length constants
	always_comb begin
		for (int j = 0; j < 8; j++) begin
			kw[j] = key[255 - 32 * j -: 32];
		end
		case (mode)
			aes_enc_pkg::KLEN_128: begin
				oldest     = win_q[3];
				last_phase = 3'd3;
				total      = aes_enc_pkg::WORDS_128;
				first_idx  = IW'(4);
			end
			aes_enc_pkg::KLEN_192: begin
				oldest     = win_q[5];
				last_phase = 3'd5;
				total      = aes_enc_pkg::WORDS_192;
				first_idx  = IW'(6);
			end
			default: begin
				oldest     = win_q[7];
				last_phase = 3'd7;
				total      = aes_enc_pkg::WORDS_256;
				first_idx  = IW'(8);
			end
		endcase
	end

	// Window starts with the newest key word in slot 0
	always_comb begin
		for (int j = 0; j < 8; j++) begin
			if (3'(j) <= last_phase) begin
				win_init[j] = kw[last_phase - 3'(j)];
			end else begin
				win_init[j] = '0;
			end
		end
	end

	// Next expanded word
	always_comb begin
		tmp = win_q[0];
		if (phase_q == 3'd0) begin
			tmp = aes_enc_pkg::sub_word({win_q[0][23:0], win_q[0][31:24]}) ^ {rcon_q, 24'h0};
		end else if (mode != aes_enc_pkg::KLEN_128 && mode != aes_enc_pkg::KLEN_192
				&& phase_q == 3'd4) begin
			tmp = aes_enc_pkg::sub_word(win_q[0]);
		end
		new_word = oldest ^ tmp;
	end

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q <= 1'b1;
			run_q  <= 1'b0;
		end else if (start) begin
			load_q <= 1'b1;
			run_q  <= 1'b0;
		end else if (load_q) begin
			load_q <= 1'b0;
			run_q  <= 1'b1;
		end else if (run_q && idx_q == total - IW'(1)) begin
			run_q <= 1'b0;
		end
	end

	// Window, counters and round key registers
	always_ff @(posedge clk) begin
		if (load_q) begin
			idx_q   <= first_idx;
			phase_q <= 3'd0;
			rcon_q  <= 8'h01;
			for (int j = 0; j < 8; j++) begin
				win_q[j] <= win_init[j];
				rk_q[j]  <= kw[j];
			end
		end else if (run_q) begin
			rk_q[idx_q] <= new_word;
			win_q[0]    <= new_word;
			for (int j = 1; j < 8; j++) begin
				win_q[j] <= win_q[j - 1];
			end
			idx_q   <= idx_q + IW'(1);
			phase_q <= (phase_q == last_phase) ? 3'd0 : phase_q + 3'd1;
			if (phase_q == 3'd0) begin
				rcon_q <= aes_enc_pkg::xtime(rcon_q);
			end
		end
	end

	always_comb begin
		for (int j = 0; j < KW; j++) begin
			rk[KW * 32 - 1 - 32 * j -: 32] = rk_q[j];
		end
	end

endmodule

[hw/rtl/aes_block_encrypt_core.sv]
// Top level of the AES-128/192/256 ECB encrypt core.
// Depends on aes_enc_pkg, aes_enc_cell and aes_enc_kexp.
//
// Takes one 128-bit block per cycle when neither in_stall nor out_stall is
// high; each block passes the input key-add stage and then the chain of 14
// round cells, whatever the key length (rounds past the last one pass the
// state through). After reset and after every write to the key length or
// key part registers the key expansion unit produces one round-key word per
// cycle, and in_stall stays high while it runs. Key length code 3 acts as
// 256 bits.
module aes_block_encrypt_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] block_high,
	input  logic [63:0] block_low,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] cipher_high,
	output logic [63:0] cipher_low
);

	localparam int NR = aes_enc_pkg::MaxRounds;
	localparam int KW = aes_enc_pkg::KeyWords;

	logic [1:0]         klen_q;
	logic [63:0]        kpart_q [4];
	aes_enc_pkg::klen_t mode;
	logic [3:0]         nrounds;
	logic               kstart;
	logic               kbusy;
	logic [KW*32-1:0]   rk;

	logic               v_s0;
	logic [127:0]       st_s0;
	logic               rdy0;
	logic               in_take;

	logic               cvalid [NR + 1];
	logic [127:0]       cstate [NR + 1];
	logic               crdy   [NR + 2];

	// Configuration registers
	assign kstart = cfg_we && cfg_index <= aes_enc_pkg::REG_KEY_PART_3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			klen_q <= '0;
			for (int j = 0; j < 4; j++) begin
				kpart_q[j] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				aes_enc_pkg::REG_KEY_LENGTH: klen_q     <= cfg_data[1:0];
				aes_enc_pkg::REG_KEY_PART_0: kpart_q[0] <= cfg_data;
				aes_enc_pkg::REG_KEY_PART_1: kpart_q[1] <= cfg_data;
				aes_enc_pkg::REG_KEY_PART_2: kpart_q[2] <= cfg_data;
				aes_enc_pkg::REG_KEY_PART_3: kpart_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Saturated key length and round count
	always_comb begin
		case (klen_q)
			aes_enc_pkg::KLEN_128: begin
				mode    = aes_enc_pkg::KLEN_128;
				nrounds = aes_enc_pkg::ROUNDS_128;
			end
			aes_enc_pkg::KLEN_192: begin
				mode    = aes_enc_pkg::KLEN_192;
				nrounds = aes_enc_pkg::ROUNDS_192;
			end
			default: begin
				mode    = aes_enc_pkg::KLEN_256;
				nrounds = aes_enc_pkg::ROUNDS_256;
			end
		endcase
	end

	aes_enc_kexp u_kexp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (kstart),
		.mode   (mode),
		.key    ({kpart_q[0], kpart_q[1], kpart_q[2], kpart_q[3]}),
		.busy   (kbusy),
		.rk     (rk)
	);

	// Input stage: initial key add
	assign rdy0     = !v_s0 || crdy[1];
	assign in_stall = kbusy || !rdy0;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else if (rdy0) begin
			v_s0 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy0) begin
			st_s0 <= {block_high, block_low} ^ rk[KW * 32 - 1 -: 128];
		end
	end

	assign cvalid[0]  = v_s0;
	assign cstate[0]  = st_s0;
	assign crdy[0]    = rdy0;
	assign crdy[NR + 1] = !out_stall;

	// Chain of round cells
	for (genvar g = 1; g <= NR; g++) begin : g_cell
		aes_enc_pkg::cell_ctl_t ctl;

		assign ctl.bypass = 4'(g) > nrounds;
		assign ctl.last   = 4'(g) == nrounds;

		aes_enc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.rkey     (rk[KW * 32 - 1 - 128 * g -: 128]),
			.valid_in (cvalid[g - 1]),
			.state_in (cstate[g - 1]),
			.ready_dn (crdy[g + 1]),
			.ready_up (crdy[g]),
			.valid_q  (cvalid[g]),
			.state_q  (cstate[g])
		);
	end

	assign out_valid   = cvalid[NR];
	assign cipher_high = cstate[NR][127:64];
	assign cipher_low  = cstate[NR][63:0];

endmodule

[hw/rtl/aes_enc_checker.sv]
// Port-level checks for the AES encrypt core, bound to its top level.
// Depends on assert_macros.svh and aes_enc_pkg.
`include "assert_macros.svh"

module aes_enc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_we,
	input logic [2:0]  cfg_index,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall
);

	// A waiting result is not withdrawn
	`AEC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")

	// A key write starts key expansion, which blocks input
	`AEC_ASSERT(a_key_busy, cfg_we && cfg_index <= aes_enc_pkg::REG_KEY_PART_3 |=> in_stall, "input open during key expansion")

	// Round keys are expanded after reset before any item enters
	`AEC_ASSERT_ANY(a_rst_busy, $rose(arst_n) |-> in_stall, "input open right after reset")

endmodule

bind aes_block_encrypt_core aes_enc_checker u_aes_enc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_we    (cfg_we),
	.cfg_index (cfg_index),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall)
);
